// ----- design/l2n_pkg.sv -----
// l2n_pkg: shared constants and types for the L2 vector normalizer.
// No dependencies.
package l2n_pkg;

    localparam int DEF_MAX_TERMS = 64;
    localparam int WEIGHT_W      = 16;
    localparam int SUM_W         = 37;
    localparam int ROOT_W        = 32;
    localparam int RAD_W         = 2 * ROOT_W;
    localparam int SQRT_SHIFT    = 26;
    localparam int REM_W         = ROOT_W + 2;
    localparam int QUOT_W        = 15;
    localparam int DIV_PRESHIFT  = 12;
    localparam int STEP_W        = 5;
    localparam logic [QUOT_W-1:0] UNIT_ONE = 15'd16384;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQRT,
        B_READ,
        B_LOAD,
        B_DIV,
        B_EMIT
    } back_state_t;

endpackage

// ----- design/l2n_ram.sv -----
// l2n_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module l2n_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- design/l2n_queue.sv -----
// l2n_queue: two-entry job queue between front and back.
// Depends on nothing but its parameter.
module l2n_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    assign head  = entry_reg[rd_ptr_reg];
    assign full  = count_reg[1];
    assign empty = (count_reg == 2'd0);

endmodule

// ----- design/l2n_front.sv -----
// l2n_front: accepts weights, stores them, sums squares, hands off vectors.
// Depends on l2n_pkg.
module l2n_front #(
    parameter int MAX_TERMS = l2n_pkg::DEF_MAX_TERMS,
    parameter int IDX_W     = 6,
    parameter int CNT_W     = 7
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [l2n_pkg::WEIGHT_W-1:0] weight,
    input  logic                         last_term,
    input  logic                         q_full,
    output logic                         q_push,
    output logic                         q_bank,
    output logic [l2n_pkg::SUM_W-1:0]    q_sum,
    output logic [CNT_W-1:0]             q_count,
    output logic                         q_drop,
    output logic                         wr_en,
    output logic [IDX_W:0]               wr_addr,
    output logic [l2n_pkg::WEIGHT_W-1:0] wr_data
);

    logic [l2n_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      drop_reg, drop_next;
    logic                      bank_reg;
    logic                      accept;
    logic                      room;
    logic signed [31:0]        square;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;
    assign room     = (count_reg < CNT_W'(MAX_TERMS));
    assign square   = $signed(weight) * $signed(weight);

    always_comb
    begin
        sum_next   = sum_reg;
        count_next = count_reg;
        drop_next  = drop_reg;
        if (room)
        begin
            sum_next   = sum_reg + {{(l2n_pkg::SUM_W-32){1'b0}}, square};
            count_next = count_reg + CNT_W'(1);
        end
        else
        begin
            drop_next = 1'b1;
        end
    end

    assign wr_en   = accept && room;
    assign wr_addr = {bank_reg, count_reg[IDX_W-1:0]};
    assign wr_data = weight;
    assign q_push  = accept && last_term;
    assign q_bank  = bank_reg;
    assign q_sum   = sum_next;
    assign q_count = count_next;
    assign q_drop  = drop_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            drop_reg  <= 1'b0;
            bank_reg  <= 1'b0;
        end
        else if (accept)
        begin
            if (last_term)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
                drop_reg  <= 1'b0;
                bank_reg  <= ~bank_reg;
            end
            else
            begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
                drop_reg  <= drop_next;
            end
        end
    end

endmodule

// ----- design/l2n_back.sv -----
// l2n_back: square root of the vector's sum, then one division per stored weight.
// Depends on l2n_pkg.
module l2n_back #(
    parameter int IDX_W = 6,
    parameter int CNT_W = 7
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  logic                         q_bank,
    input  logic [l2n_pkg::SUM_W-1:0]    q_sum,
    input  logic [CNT_W-1:0]             q_count,
    input  logic                         q_drop,
    output logic                         q_pop,
    output logic                         rd_en,
    output logic [IDX_W:0]               rd_addr,
    input  logic [l2n_pkg::WEIGHT_W-1:0] rd_data,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [l2n_pkg::WEIGHT_W-1:0] unit_weight,
    output logic                         last_result,
    output logic                         overflowed
);

    localparam int RW = l2n_pkg::ROOT_W;

    l2n_pkg::back_state_t state_reg, state_next;

    logic [l2n_pkg::RAD_W-1:0]   rad_reg;
    logic [l2n_pkg::REM_W-1:0]   srem_reg;
    logic [RW-1:0]               root_reg;
    logic [RW-1:0]               drem_reg;
    logic [l2n_pkg::QUOT_W-1:0]  quot_reg;
    logic                        neg_reg;
    logic [l2n_pkg::STEP_W-1:0]  step_reg;
    logic [CNT_W-1:0]            idx_reg;
    logic                        out_valid_reg;
    logic [l2n_pkg::WEIGHT_W-1:0] out_data_reg;
    logic                        out_last_reg;
    logic                        out_drop_reg;

    logic [l2n_pkg::REM_W-1:0]   s_shift, s_trial;
    logic                        s_take;
    logic [RW:0]                 d_shift;
    logic                        d_take;
    logic [l2n_pkg::WEIGHT_W-1:0] mag;
    logic [l2n_pkg::QUOT_W-1:0]  quot_clamp;
    logic [l2n_pkg::WEIGHT_W-1:0] result;
    logic                        is_last;
    logic                        out_free;
    logic                        load_out;

    assign s_shift = {srem_reg[l2n_pkg::REM_W-3:0], rad_reg[l2n_pkg::RAD_W-1 -: 2]};
    assign s_trial = {root_reg, 2'b01};
    assign s_take  = (s_shift >= s_trial);
    assign d_shift = {drem_reg, 1'b0};
    assign d_take  = (d_shift >= {1'b0, root_reg});
    assign mag     = rd_data[l2n_pkg::WEIGHT_W-1] ? (~rd_data + 1'b1) : rd_data;
    assign quot_clamp = (quot_reg > l2n_pkg::UNIT_ONE) ? l2n_pkg::UNIT_ONE : quot_reg;
    assign result  = (root_reg == '0) ? '0 :
                     (neg_reg ? (~{1'b0, quot_clamp} + 1'b1) : {1'b0, quot_clamp});
    assign is_last = (idx_reg + CNT_W'(1) == q_count);
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            l2n_pkg::B_IDLE:
                if (!q_empty)
                begin
                    state_next = l2n_pkg::B_SQRT;
                end
            l2n_pkg::B_SQRT:
                if (step_reg == '1)
                begin
                    state_next = l2n_pkg::B_READ;
                end
            l2n_pkg::B_READ:
                state_next = l2n_pkg::B_LOAD;
            l2n_pkg::B_LOAD:
                state_next = l2n_pkg::B_DIV;
            l2n_pkg::B_DIV:
                if (step_reg == l2n_pkg::STEP_W'(l2n_pkg::QUOT_W - 1))
                begin
                    state_next = l2n_pkg::B_EMIT;
                end
            l2n_pkg::B_EMIT:
                if (out_free)
                begin
                    state_next = is_last ? l2n_pkg::B_IDLE : l2n_pkg::B_READ;
                end
            default:
                state_next = l2n_pkg::B_IDLE;
        endcase
    end

    always_comb
    begin
        rd_en    = (state_reg == l2n_pkg::B_READ);
        rd_addr  = {q_bank, idx_reg[IDX_W-1:0]};
        load_out = (state_reg == l2n_pkg::B_EMIT) && out_free;
        q_pop    = load_out && is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= l2n_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                l2n_pkg::B_IDLE:
                begin
                    step_reg <= '0;
                    idx_reg  <= '0;
                end
                l2n_pkg::B_SQRT:
                    step_reg <= step_reg + 1'b1;
                l2n_pkg::B_LOAD:
                    step_reg <= '0;
                l2n_pkg::B_DIV:
                    step_reg <= step_reg + 1'b1;
                l2n_pkg::B_EMIT:
                    if (load_out)
                    begin
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                default:
                    step_reg <= step_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            l2n_pkg::B_IDLE:
            begin
                rad_reg  <= {1'b0, q_sum, {l2n_pkg::SQRT_SHIFT{1'b0}}};
                srem_reg <= '0;
                root_reg <= '0;
            end
            l2n_pkg::B_SQRT:
            begin
                rad_reg <= {rad_reg[l2n_pkg::RAD_W-3:0], 2'b00};
                if (s_take)
                begin
                    srem_reg <= s_shift - s_trial;
                    root_reg <= {root_reg[RW-2:0], 1'b1};
                end
                else
                begin
                    srem_reg <= s_shift;
                    root_reg <= {root_reg[RW-2:0], 1'b0};
                end
            end
            l2n_pkg::B_LOAD:
            begin
                drem_reg <= {{(RW-l2n_pkg::WEIGHT_W-l2n_pkg::DIV_PRESHIFT){1'b0}},
                             mag, {l2n_pkg::DIV_PRESHIFT{1'b0}}};
                neg_reg  <= rd_data[l2n_pkg::WEIGHT_W-1];
                quot_reg <= '0;
            end
            l2n_pkg::B_DIV:
            begin
                if (d_take)
                begin
                    drem_reg <= RW'(d_shift - {1'b0, root_reg});
                end
                else
                begin
                    drem_reg <= d_shift[RW-1:0];
                end
                quot_reg <= {quot_reg[l2n_pkg::QUOT_W-2:0], d_take};
            end
            l2n_pkg::B_EMIT:
                if (load_out)
                begin
                    out_data_reg <= result;
                    out_last_reg <= is_last;
                    out_drop_reg <= q_drop;
                end
            default:
                neg_reg <= neg_reg;
        endcase
    end

    assign m_tvalid    = out_valid_reg;
    assign unit_weight = out_data_reg;
    assign last_result = out_last_reg;
    assign overflowed  = out_drop_reg;

endmodule

// ----- design/l2_normalize_vector.sv -----
// l2_normalize_vector: top level of the L2 vector normalizer.
// Depends on l2n_pkg, l2n_ram, l2n_queue, l2n_front, l2n_back.
//
// Weights (signed Q8.8) stream in one per beat; tlast closes a vector. Each
// vector is emitted as weight / norm in signed Q1.14, in arrival order, with
// tlast on the final result and tuser set when terms past MAX_TERMS were
// dropped. An all-zero vector yields zeros. The front takes one beat per
// cycle while the queue is not full; the back takes a vector's square root,
// then per result does a RAM read, the 15-step divider and an output load.
// Two vectors may be queued; the front stalls while a third would be held.
module l2_normalize_vector #(
    parameter int MAX_TERMS = l2n_pkg::DEF_MAX_TERMS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] weight
    input  logic        s_tlast,   // last_term
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] unit_weight
    output logic        m_tlast,   // last_result
    output logic        m_tuser    // [0] overflowed
);

    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int JOB_W = 1 + l2n_pkg::SUM_W + CNT_W + 1;

    logic                         q_full, q_empty, q_push, q_pop;
    logic                         f_bank, f_drop;
    logic [l2n_pkg::SUM_W-1:0]    f_sum;
    logic [CNT_W-1:0]             f_count;
    logic [JOB_W-1:0]             head;
    logic                         wr_en, rd_en;
    logic [IDX_W:0]               wr_addr, rd_addr;
    logic [l2n_pkg::WEIGHT_W-1:0] wr_data, rd_data;

    l2n_front #(
        .MAX_TERMS (MAX_TERMS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .weight    (s_tdata),
        .last_term (s_tlast),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_bank    (f_bank),
        .q_sum     (f_sum),
        .q_count   (f_count),
        .q_drop    (f_drop),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    l2n_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({f_bank, f_sum, f_count, f_drop}),
        .pop       (q_pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    l2n_ram #(
        .WIDTH (l2n_pkg::WEIGHT_W),
        .DEPTH (2 << IDX_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    l2n_back #(
        .IDX_W (IDX_W),
        .CNT_W (CNT_W)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_bank      (head[JOB_W-1]),
        .q_sum       (head[JOB_W-2 -: l2n_pkg::SUM_W]),
        .q_count     (head[CNT_W:1]),
        .q_drop      (head[0]),
        .q_pop       (q_pop),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .unit_weight (m_tdata),
        .last_result (m_tlast),
        .overflowed  (m_tuser)
    );

endmodule

// ----- tb/l2_normalize_vector_test.sv -----
// l2_normalize_vector_test: self-checking testbench for the L2 vector normalizer.
// Depends on l2n_pkg and l2_normalize_vector; predicts each unit weight in-bench.
module l2_normalize_vector_test;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] unit_weight;
        logic        last_result;
        logic        overflowed;
    } unit_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    logic signed [15:0] vec_weights[$];
    logic [36:0]        vec_sq_sum;
    logic               vec_dropped;
    unit_beat_t         unit_queue[$];
    int                 fail_count = 0;
    int                 beats_sent = 0;
    int                 units_seen = 0;
    int                 vectors_sent = 0;
    bit                 hold_off = 1'b0;
    bit                 no_gaps = 1'b0;

    l2_normalize_vector u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .m_tuser(m_tuser)
    );

    always #2 clk = ~clk;

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] bitv;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Update vector state with one accepted beat; on tlast queue the unit weights.
    task automatic predict_units(input logic signed [15:0] w, input logic last);
        logic [63:0] root;
        logic [63:0] mag;
        logic [63:0] q;
        logic [15:0] res;
        unit_beat_t  ub;
        int          n;
        if (vec_weights.size() < l2n_pkg::DEF_MAX_TERMS)
        begin
            mag = (w < 0) ? 64'(-32'(w)) : 64'(w);
            vec_weights.push_back(w);
            vec_sq_sum = vec_sq_sum + 37'(mag * mag);
        end
        else
            vec_dropped = 1'b1;
        if (last)
        begin
            root = int_sqrt(64'(vec_sq_sum) << 26);
            n = vec_weights.size();
            for (int i = 0; i < n; i++)
            begin
                mag = (vec_weights[i] < 0) ? 64'(-32'(vec_weights[i])) : 64'(vec_weights[i]);
                q = (root != 0) ? (mag << 27) / root : 64'd0;
                if (q > 64'd16384)
                    q = 64'd16384;
                res = q[15:0];
                if (vec_weights[i] < 0)
                    res = -res;
                ub.unit_weight = res;
                ub.last_result = (i == n - 1);
                ub.overflowed = vec_dropped;
                unit_queue.push_back(ub);
            end
            vec_weights.delete();
            vec_sq_sum = '0;
            vec_dropped = 1'b0;
            vectors_sent++;
        end
    endtask

    // tvalid stays high after a beat and drops only for an idle gap or a drain wait.
    task automatic send_weight(input logic [15:0] w, input logic last);
        int gap;
        if (!no_gaps)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= w;
        s_tlast <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_units(w, last);
        beats_sent++;
    endtask

    task automatic send_vector(input int len, input int mode);
        logic [15:0] w;
        for (int i = 0; i < len; i++)
        begin
            case (mode)
                0: w = 16'($urandom);
                1: w = 16'($urandom_range(0, 1023)) - 16'd512;
                2: w = 16'h0000;
                default: w = ($urandom_range(0, 1)) ? 16'h8000 : 16'h7FFF;
            endcase
            send_weight(w, i == len - 1);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (unit_queue.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic test_directed();
        send_weight(16'h7FFF, 1'b1);
        send_weight(16'h8000, 1'b1);
        send_weight(16'h0000, 1'b1);
        send_weight(16'h0000, 1'b0);
        send_weight(16'h0000, 1'b1);
        send_weight(16'h0100, 1'b0);
        send_weight(16'hFF00, 1'b0);
        send_weight(16'h0001, 1'b0);
        send_weight(16'hFFFF, 1'b1);
        send_weight(16'h8000, 1'b0);
        send_weight(16'h8000, 1'b0);
        send_weight(16'h7FFF, 1'b1);
        send_weight(16'h5555, 1'b0);
        send_weight(16'hAAAA, 1'b1);
        wait_drained();
    endtask

    task automatic test_capacity();
        send_vector(66, 3);
        wait_drained();
    endtask

    task automatic test_random();
        int n;
        n = 0;
        while (n < 24)
        begin
            int len;
            int mode;
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 6);
            mode = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 1) : $urandom_range(2, 3);
            send_vector(len, mode);
            n += len;
        end
        wait_drained();
    endtask

    task automatic test_backpressure();
        no_gaps = 1'b1;
        hold_off = 1'b1;
        fork
            begin
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int v = 0; v < 5; v++)
                    send_vector(4, 0);
            end
        join
        no_gaps = 1'b0;
        wait_drained();
    endtask

    // Output ready with random gaps, forced low during a hold-off.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
                m_tready <= 1'b0;
            else if ($urandom_range(0, 3) == 0)
            begin
                m_tready <= 1'b0;
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
                repeat (gap) @(posedge clk);
                m_tready <= !hold_off;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        unit_beat_t exp_b;
        if (rst_n && m_tvalid && m_tready)
        begin
            units_seen++;
            if (unit_queue.size() == 0)
            begin
                $error("unexpected beat: unit_weight %0d", $signed(m_tdata));
                fail_count++;
            end
            else
            begin
                exp_b = unit_queue.pop_front();
                if (m_tdata !== exp_b.unit_weight)
                begin
                    $error("unit_weight expected %0d actual %0d",
                           $signed(exp_b.unit_weight), $signed(m_tdata));
                    fail_count++;
                end
                if (m_tlast !== exp_b.last_result)
                begin
                    $error("last_result expected %0d actual %0d", exp_b.last_result, m_tlast);
                    fail_count++;
                end
                if (m_tuser !== exp_b.overflowed)
                begin
                    $error("overflowed expected %0d actual %0d", exp_b.overflowed, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #4000000;
        $display("FAIL l2_normalize_vector");
        $finish;
    end

    initial
    begin
        vec_sq_sum = '0;
        vec_dropped = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_capacity();
        test_backpressure();
        test_random();
        if (unit_queue.size() != 0)
        begin
            $error("%0d unit weights never arrived", unit_queue.size());
            fail_count++;
        end
        $display("Covered %0d input beats in %0d vectors, %0d unit weights checked,",
                 beats_sent, vectors_sent, units_seen);
        $display("including extremes, zero norm, dropped terms and output stall.");
        if (fail_count == 0)
            $display("PASS l2_normalize_vector");
        else
            $display("FAIL l2_normalize_vector");
        $finish;
    end
endmodule

// ----- l2_normalize_vector.f -----
design/l2n_pkg.sv
design/l2n_ram.sv
design/l2n_queue.sv
design/l2n_front.sv
design/l2n_back.sv
design/l2_normalize_vector.sv
tb/l2_normalize_vector_test.sv
